>>> rtl/lzkh_pkg.sv
// Shared types and constants for the LZRW1/KH stream decompressor.
package lzkh_pkg;

   localparam int HistDepth     = 4096;
   localparam int HistAddrWidth = $clog2(HistDepth);
   localparam int LenWidth      = 24;
   localparam int ByteWidth     = 8;
   localparam int CountWidth    = 13;
   localparam int OffsetWidth   = 12;
   localparam int CopyLenWidth  = 5;
   localparam int BitsWidth     = 5;
   localparam int CmdWidth      = 16;

   localparam logic [ByteWidth-1:0]    FlagReset  = 8'd128;
   localparam logic [CopyLenWidth-1:0] CopyBias   = 5'd3;
   localparam logic [CountWidth-1:0]   RunBias    = 13'd16;
   localparam logic [BitsWidth-1:0]    CmdBits    = 5'd16;

   localparam int ReqDataWidth = ByteWidth;
   localparam int RspFieldBits = ByteWidth + CountWidth + LenWidth;
   localparam int RspDataWidth = ((RspFieldBits + 7) / 8) * 8;

   typedef enum logic [2:0] {
      PhIdle,
      PhCmdHi,
      PhCmdLo,
      PhToken,
      PhRef2,
      PhRun3,
      PhRun4,
      PhCopy
   } phase_type;

   typedef enum logic [2:0] {
      EngIdle,
      EngEmit,
      EngFill,
      EngCopyRd,
      EngCopyWr
   } eng_state_type;

   typedef enum logic {
      JobBytes,
      JobCopy
   } job_kind_type;

   // One decoded token handed from the parser to the emit engine.
   typedef struct packed {
      logic                    start;
      logic                    clear_len;
      job_kind_type            kind;
      logic [ByteWidth-1:0]    value;
      logic [CountWidth-1:0]   count;
      logic [OffsetWidth-1:0]  pos;
      logic [CopyLenWidth-1:0] copy_len;
      logic                    last;
   } job_type;

   typedef struct packed {
      logic                     wr_en;
      logic [HistAddrWidth-1:0] wr_addr;
      logic [ByteWidth-1:0]     wr_data;
      logic                     rd_en;
      logic [HistAddrWidth-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [ByteWidth-1:0]  out_byte;
      logic [CountWidth-1:0] repeat_count;
      logic                  run_last;
      logic                  image_done;
      logic [LenWidth-1:0]   output_length;
   } out_item_type;

endpackage

>>> rtl/lzkh_hist_ram.sv
// History ring: one write port, one registered read port, write-first on a collision.
module lzkh_hist_ram (
   input  logic                                  clock,
   input  lzkh_pkg::ram_req_type                 req,
   output logic [lzkh_pkg::ByteWidth-1:0]        rd_data
);

   logic [lzkh_pkg::ByteWidth-1:0] mem [lzkh_pkg::HistDepth];
   logic [lzkh_pkg::ByteWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   // An overlapping copy reads the entry written in the same cycle.
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
            rd_data_ff <= req.wr_data;
         end else begin
            rd_data_ff <= mem[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lzkh_out_reg.sv
// Output register that holds one result word until the receiver takes it.
module lzkh_out_reg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  lzkh_pkg::out_item_type                item,
   output logic                                  slot_free,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lzkh_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   logic                   valid_ff;
   logic                   valid_in;
   lzkh_pkg::out_item_type item_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = lzkh_pkg::RspDataWidth'({item_ff.output_length,
                                                item_ff.repeat_count,
                                                item_ff.out_byte});
   assign rsp_tuser  = item_ff.image_done;
   assign rsp_tlast  = item_ff.run_last;

endmodule

>>> rtl/lzkh_parser.sv
// Token parser: flag byte, command words and token bytes into engine jobs.
module lzkh_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lzkh_pkg::ByteWidth-1:0]        csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lzkh_pkg::ReqDataWidth-1:0]     req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   input  logic                                  eng_idle,
   output lzkh_pkg::job_type                     job
);

   lzkh_pkg::phase_type                phase_ff, phase_in;
   logic [lzkh_pkg::CmdWidth-1:0]      cmd_ff, cmd_in;
   logic [lzkh_pkg::BitsWidth-1:0]     bits_ff, bits_in;
   logic [lzkh_pkg::ByteWidth-1:0]     tok0_ff, tok0_in;
   logic [3:0]                         tok1_ff, tok1_in;
   logic [lzkh_pkg::ByteWidth-1:0]     tok2_ff, tok2_in;
   logic [lzkh_pkg::ByteWidth-1:0]     flag_ff;

   logic                               accept;
   logic                               emit;
   logic [lzkh_pkg::ByteWidth-1:0]     in_byte;
   logic [lzkh_pkg::BitsWidth-1:0]     bits_dec;
   logic [lzkh_pkg::OffsetWidth-1:0]   ref_pos;

   assign req_tready = eng_idle;
   assign accept     = req_tvalid && eng_idle;
   assign in_byte    = req_tdata[lzkh_pkg::ByteWidth-1:0];
   assign bits_dec   = (bits_ff != '0) ? bits_ff - 5'd1 : bits_ff;
   assign ref_pos    = {tok0_ff, in_byte[7:4]};

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= lzkh_pkg::FlagReset;
         phase_ff <= lzkh_pkg::PhIdle;
         cmd_ff   <= '0;
         bits_ff  <= '0;
         tok0_ff  <= '0;
         tok1_ff  <= '0;
         tok2_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            flag_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         bits_ff  <= bits_in;
         tok0_ff  <= tok0_in;
         tok1_ff  <= tok1_in;
         tok2_ff  <= tok2_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      bits_in  = bits_ff;
      tok0_in  = tok0_ff;
      tok1_in  = tok1_ff;
      tok2_in  = tok2_ff;
      emit     = 1'b0;
      job      = '0;
      job.kind = lzkh_pkg::JobBytes;

      if (accept) begin
         if (req_tuser) begin
            cmd_in        = '0;
            bits_in       = '0;
            tok0_in       = '0;
            tok1_in       = '0;
            tok2_in       = '0;
            job.clear_len = 1'b1;
            phase_in      = (in_byte == flag_ff) ? lzkh_pkg::PhCopy : lzkh_pkg::PhCmdHi;
         end else begin
            unique case (phase_ff)
               lzkh_pkg::PhIdle: begin
               end
               lzkh_pkg::PhCmdHi: begin
                  cmd_in   = {in_byte, 8'h00};
                  phase_in = lzkh_pkg::PhCmdLo;
               end
               lzkh_pkg::PhCmdLo: begin
                  cmd_in   = {cmd_ff[15:8], in_byte};
                  bits_in  = lzkh_pkg::CmdBits;
                  phase_in = lzkh_pkg::PhToken;
               end
               lzkh_pkg::PhToken: begin
                  if (cmd_ff[15]) begin
                     tok0_in  = in_byte;
                     phase_in = lzkh_pkg::PhRef2;
                  end else begin
                     emit      = 1'b1;
                     job.value = in_byte;
                     job.count = 13'd1;
                  end
               end
               lzkh_pkg::PhRef2: begin
                  if (ref_pos == '0) begin
                     tok1_in  = in_byte[3:0];
                     phase_in = lzkh_pkg::PhRun3;
                  end else begin
                     emit         = 1'b1;
                     job.kind     = lzkh_pkg::JobCopy;
                     job.pos      = ref_pos;
                     job.copy_len = lzkh_pkg::CopyLenWidth'(in_byte[3:0]) + lzkh_pkg::CopyBias;
                  end
               end
               lzkh_pkg::PhRun3: begin
                  tok2_in  = in_byte;
                  phase_in = lzkh_pkg::PhRun4;
               end
               lzkh_pkg::PhRun4: begin
                  emit      = 1'b1;
                  job.value = in_byte;
                  job.count = lzkh_pkg::CountWidth'({tok1_ff, tok2_ff}) + lzkh_pkg::RunBias;
               end
               lzkh_pkg::PhCopy: begin
                  emit      = 1'b1;
                  job.value = in_byte;
                  job.count = 13'd1;
               end
            endcase

            // A token that produced output consumes one command bit.
            if (emit && (phase_ff != lzkh_pkg::PhCopy)) begin
               cmd_in   = {cmd_ff[14:0], 1'b0};
               bits_in  = bits_dec;
               phase_in = (bits_dec == '0) ? lzkh_pkg::PhCmdHi : lzkh_pkg::PhToken;
            end
         end

         if (req_tlast) begin
            phase_in = lzkh_pkg::PhIdle;
            job.last = 1'b1;
         end
         job.start = emit || req_tlast;
      end
   end

endmodule

>>> rtl/lzkh_engine.sv
// Emit engine: writes the history ring, runs back-reference copies and fills runs.
module lzkh_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lzkh_pkg::job_type                     job,
   output logic                                  eng_idle,
   output lzkh_pkg::ram_req_type                 ram_req,
   input  logic [lzkh_pkg::ByteWidth-1:0]        ram_rd_data,
   input  logic                                  slot_free,
   output logic                                  out_load,
   output lzkh_pkg::out_item_type                out_item
);

   localparam int SumWidth = lzkh_pkg::LenWidth + 1;
   localparam int AddrW    = lzkh_pkg::HistAddrWidth;

   lzkh_pkg::eng_state_type               state_ff, state_in;
   logic [lzkh_pkg::ByteWidth-1:0]        value_ff, value_in;
   logic [lzkh_pkg::CountWidth-1:0]       count_ff, count_in;
   logic [lzkh_pkg::CountWidth-1:0]       left_ff, left_in;
   logic [lzkh_pkg::OffsetWidth-1:0]      pos_ff, pos_in;
   logic                                  last_ff, last_in;
   logic [AddrW-1:0]                      wp_ff, wp_in;
   logic [lzkh_pkg::LenWidth-1:0]         prod_ff, prod_in;

   logic [SumWidth-1:0]                   len_sum;
   logic [lzkh_pkg::LenWidth-1:0]         len_sat;
   logic [lzkh_pkg::CountWidth-1:0]       add_count;
   logic [AddrW-1:0]                      pos_ext;

   assign eng_idle = (state_ff == lzkh_pkg::EngIdle);
   assign pos_ext  = AddrW'(pos_ff);

   // Saturating length update; a copy adds one byte at a time.
   assign add_count = (state_ff == lzkh_pkg::EngCopyWr) ? 13'd1 : count_ff;
   assign len_sum   = SumWidth'(prod_ff) + SumWidth'(add_count);
   assign len_sat   = len_sum[SumWidth-1] ? '1 : len_sum[lzkh_pkg::LenWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzkh_pkg::EngIdle;
         wp_ff    <= '0;
         prod_ff  <= '0;
         value_ff <= '0;
         count_ff <= '0;
         left_ff  <= '0;
         pos_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         prod_ff  <= prod_in;
         value_ff <= value_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      prod_in  = prod_ff;
      value_in = value_ff;
      count_in = count_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      ram_req  = '0;
      out_load = 1'b0;
      out_item = '0;

      unique case (state_ff)
         lzkh_pkg::EngIdle: begin
            if (job.clear_len) begin
               prod_in = '0;
            end
            if (job.start) begin
               value_in = job.value;
               count_in = job.count;
               pos_in   = job.pos;
               last_in  = job.last;
               if (job.kind == lzkh_pkg::JobCopy) begin
                  left_in  = lzkh_pkg::CountWidth'(job.copy_len);
                  state_in = lzkh_pkg::EngCopyRd;
               end else begin
                  state_in = lzkh_pkg::EngEmit;
               end
            end
         end
         lzkh_pkg::EngEmit: begin
            if (slot_free) begin
               out_load               = 1'b1;
               out_item.out_byte      = value_ff;
               out_item.repeat_count  = count_ff;
               out_item.run_last      = 1'b1;
               out_item.image_done    = last_ff;
               out_item.output_length = len_sat;
               prod_in                = len_sat;
               if (count_ff != '0) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = wp_ff;
                  ram_req.wr_data = value_ff;
                  wp_in           = wp_ff + 1'b1;
                  left_in         = count_ff - 13'd1;
                  state_in        = (count_ff == 13'd1) ? lzkh_pkg::EngIdle : lzkh_pkg::EngFill;
               end else begin
                  state_in = lzkh_pkg::EngIdle;
               end
            end
         end
         lzkh_pkg::EngFill: begin
            // The rest of a run goes into the ring, one entry per cycle.
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = wp_ff;
            ram_req.wr_data = value_ff;
            wp_in           = wp_ff + 1'b1;
            left_in         = left_ff - 13'd1;
            if (left_ff == 13'd1) begin
               state_in = lzkh_pkg::EngIdle;
            end
         end
         lzkh_pkg::EngCopyRd: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = wp_ff - pos_ext;
            state_in        = lzkh_pkg::EngCopyWr;
         end
         lzkh_pkg::EngCopyWr: begin
            if (slot_free) begin
               out_load               = 1'b1;
               out_item.out_byte      = ram_rd_data;
               out_item.repeat_count  = 13'd1;
               out_item.run_last      = (left_ff == 13'd1);
               out_item.image_done    = last_ff && (left_ff == 13'd1);
               out_item.output_length = len_sat;
               prod_in                = len_sat;
               ram_req.wr_en          = 1'b1;
               ram_req.wr_addr        = wp_ff;
               ram_req.wr_data        = ram_rd_data;
               wp_in                  = wp_ff + 1'b1;
               left_in                = left_ff - 13'd1;
               if (left_ff == 13'd1) begin
                  state_in = lzkh_pkg::EngIdle;
               end else begin
                  // Next source byte; the RAM forwards it when it is the one written now.
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = wp_ff + 1'b1 - pos_ext;
               end
            end
         end
         default: begin
            state_in = lzkh_pkg::EngIdle;
         end
      endcase
   end

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      out_load |-> slot_free)
      else $error("result loaded while the output register is occupied");

   a_read_then_copy: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzkh_pkg::EngCopyRd |=> state_ff == lzkh_pkg::EngCopyWr)
      else $error("copy read not followed by copy write");

   a_copy_len_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzkh_pkg::EngCopyRd || state_ff == lzkh_pkg::EngCopyWr)
      |-> (left_ff != '0 && left_ff <= 13'd18))
      else $error("copy length out of range");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzkh_pkg::EngFill |-> left_ff != '0)
      else $error("run fill with nothing left");

   a_wp_steps: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |=> wp_ff == $past(wp_ff) + 1'b1)
      else $error("write pointer did not advance after a ring write");

endmodule

>>> rtl/lzrw1kh_stream_decompressor.sv
// Top level of the LZRW1/KH stream decompressor with run-length extension.
//
// Input words arrive on req_ (one compressed byte each); req_tuser marks the
// flag byte that starts an image and req_tlast its final byte. Result words
// leave on rsp_: a byte with its repeat count and the running output length;
// rsp_tlast closes the results of one input word and rsp_tuser marks the end
// of the image. csr_wr_en/csr_wr_data set the flag value of a stored image.
// Per input word, with the receiver ready: a word that yields nothing leaves
// the engine idle; a literal, a stored byte, a run item or a done-only word
// yields one result word, registered in the output register once the engine
// has taken the job; a back reference of n bytes streams one byte per cycle
// through the history RAM after its first read; a run writes its first byte
// into the history RAM with its item and the rest one entry per cycle after.
// Only one input word is in work at a time; req_tready is low meanwhile.
// The output register lets the next result be loaded while the last is taken;
// a stalled receiver holds the engine and, through it, req_tready.
// Reset clears the parser, write pointer and length; the history RAM is not
// cleared, and the flag value returns to 128.
module lzrw1kh_stream_decompressor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lzkh_pkg::ByteWidth-1:0]        csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lzkh_pkg::ReqDataWidth-1:0]     req_tdata,  // [7:0] in_byte
   input  logic                                  req_tuser,  // first_of_image
   input  logic                                  req_tlast,  // last_of_image
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] out_byte, [20:8] repeat_count, [44:21] output_length, rest zero
   output logic [lzkh_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,  // image_done
   output logic                                  rsp_tlast   // run_last
);

   lzkh_pkg::job_type               job;
   lzkh_pkg::ram_req_type           ram_req;
   lzkh_pkg::out_item_type          out_item;
   logic                            eng_idle;
   logic                            slot_free;
   logic                            out_load;
   logic [lzkh_pkg::ByteWidth-1:0]  ram_rd_data;

   lzkh_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .eng_idle    (eng_idle),
      .job         (job)
   );

   lzkh_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .eng_idle    (eng_idle),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .slot_free   (slot_free),
      .out_load    (out_load),
      .out_item    (out_item)
   );

   lzkh_hist_ram u_hist_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   lzkh_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .item       (out_item),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
